// ===== design/periodic_oneshot_timer_bank_assert.svh =====
// Assertion macros for the periodic and one-shot timer bank.
// Included by the top level; needs nothing else.
`ifndef PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timer bank assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");

`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/potb_pkg.sv =====
// Shared types and constants of the periodic and one-shot timer bank.
// Stand-alone package; used by periodic_oneshot_timer_bank.
`timescale 1ns / 1ps

package potb_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int MIN_IV_W    = 20;
    localparam logic [MIN_IV_W-1:0] MIN_IV_RESET = 20'd1000;
    localparam int MS_TO_US    = 1000;

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 8;

    // Input modes.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_DESTROY = 3'd2;
    localparam logic [2:0] MODE_START   = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;
    localparam logic [2:0] MODE_SETFL   = 3'd5;
    localparam logic [2:0] MODE_SETIV   = 3'd6;
    localparam logic [2:0] MODE_NONE    = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_IV  = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_NOT_USED = 2'd3;

    // Result kinds.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef struct packed {
        logic used;
        logic notify;
        logic direct;
        logic auto_rep;
        logic enabled;
    } t_slot_flags;

endpackage

// ===== design/periodic_oneshot_timer_bank.sv =====
// A command is captured, then executed in CMD, which puts its single result in the output
// register once that register is free; the unused mode gives no result. A tick visits one
// slot a cycle unless stalled on the output, set by the single read port of the interval
// and start memories. One item at a time; a new item is taken once the previous one is finished.
// Reset (synchronous, active low) frees every slot and loads min_interval_us with 1000;
// the interval and start memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

`include "periodic_oneshot_timer_bank_assert.svh"

module periodic_oneshot_timer_bank
    import potb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration: min_interval_us, written whenever i_cfg_we is high.
    input  logic                  i_cfg_we,
    input  logic [MIN_IV_W-1:0]   i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0: target_slot[3], now_us[32], interval_ms[23], flag_bits[3],
    // notify[1], two zero pad bits.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[3].
    input  logic [2:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0: status[2], slot[3], direct[1], two zero pad bits.
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: kind[1].
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    // The sequencer has four states. IDLE waits for a transfer, CMD executes a command or
    // starts a tick, SCAN evaluates one slot per cycle unless stalled, FLUSH releases the held fire result.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMD   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]          r_state, n_state;

    // Captured input item.
    logic [2:0]          r_mode, n_mode;
    logic [2:0]          r_tgt, n_tgt;
    logic [31:0]         r_now, n_now;
    logic [22:0]         r_ms, n_ms;
    logic [2:0]          r_fl, n_fl;
    logic                r_nt, n_nt;

    logic [MIN_IV_W-1:0] r_min;

    // Slot flags live in flip-flops: they have a reset value and the create search
    // looks at every used bit at once.
    t_slot_flags         r_flags [NUM_TIMERS];
    t_slot_flags         n_flags [NUM_TIMERS];

    // Interval and period start of each slot, one synchronous memory each.
    logic [31:0]         r_mem_iv [NUM_TIMERS];
    logic [31:0]         r_mem_st [NUM_TIMERS];
    logic [31:0]         r_iv_q;
    logic [31:0]         r_st_q;
    logic [IDX_W-1:0]    w_raddr;
    logic                w_iv_we;
    logic [IDX_W-1:0]    w_iv_waddr;
    logic [31:0]         w_iv_wdata;
    logic                w_st_we;
    logic [IDX_W-1:0]    w_st_waddr;

    // Tick scan bookkeeping.
    logic [IDX_W-1:0]    r_eidx, n_eidx;
    logic [CNT_W-1:0]    r_nres, n_nres;

    // A fire result is held back one step so that the last one of a tick can carry tlast.
    logic                r_pvld, n_pvld;
    logic [2:0]          r_pslot, n_pslot;
    logic                r_pdir, n_pdir;

    // Output register.
    logic                r_ovld, n_ovld;
    logic                r_okind, n_okind;
    logic [1:0]          r_ostat, n_ostat;
    logic [2:0]          r_oslot, n_oslot;
    logic                r_odir, n_odir;
    logic                r_olast, n_olast;

    // Decode helpers.
    logic [32:0]         w_prod;
    logic [31:0]         w_ms_us;
    logic [31:0]         w_create_iv;
    logic                w_free_found;
    logic [IDX_W-1:0]    w_free_idx;
    logic                w_tgt_in;
    logic [IDX_W-1:0]    w_tidx;
    t_slot_flags         w_tflags;
    t_slot_flags         w_eflags;
    logic [31:0]         w_elapsed;
    logic                w_hit;
    logic                w_fire;
    logic                w_stall;
    logic                w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_odir, r_oslot, r_ostat};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // Milliseconds to microseconds, wrapping modulo 2^32; create then raises it to the minimum.
    assign w_prod      = {10'd0, r_ms} * 33'(MS_TO_US);
    assign w_ms_us     = w_prod[31:0];
    assign w_create_iv = (w_ms_us < {12'd0, r_min}) ? {12'd0, r_min} : w_ms_us;

    // Lowest free slot for create.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (!r_flags[k].used) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(k);
            end
        end
    end

    // The addressed slot; a target beyond the bank reads as a free slot.
    assign w_tgt_in = (int'(r_tgt) < NUM_TIMERS);
    assign w_tidx   = IDX_W'(r_tgt);
    assign w_tflags = w_tgt_in ? r_flags[w_tidx] : '0;

    // Expiry test of the slot under evaluation, against the registered memory read.
    assign w_eflags   = r_flags[r_eidx];
    assign w_elapsed  = r_now - r_st_q;
    assign w_hit      = w_eflags.used && w_eflags.enabled && (w_elapsed >= r_iv_q);
    assign w_fire     = w_hit && w_eflags.notify && (r_nres < CNT_W'(MAX_RESULTS));
    assign w_out_free = !r_ovld || m_axis_tready;
    // A second fire result finds the holding stage full and the output blocked: wait.
    assign w_stall    = (r_state == S_SCAN) && w_fire && r_pvld && !w_out_free;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_tgt      = r_tgt;
        n_now      = r_now;
        n_ms       = r_ms;
        n_fl       = r_fl;
        n_nt       = r_nt;
        n_flags    = r_flags;
        n_eidx     = r_eidx;
        n_nres     = r_nres;
        n_pvld     = r_pvld;
        n_pslot    = r_pslot;
        n_pdir     = r_pdir;
        n_ovld     = r_ovld && !m_axis_tready;
        n_okind    = r_okind;
        n_ostat    = r_ostat;
        n_oslot    = r_oslot;
        n_odir     = r_odir;
        n_olast    = r_olast;
        w_raddr    = r_eidx + IDX_W'(1);
        w_iv_we    = 1'b0;
        w_iv_waddr = w_tidx;
        w_iv_wdata = w_ms_us;
        w_st_we    = 1'b0;
        w_st_waddr = w_tidx;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_tgt   = s_axis_tdata[2:0];
                    n_now   = s_axis_tdata[34:3];
                    n_ms    = s_axis_tdata[57:35];
                    n_fl    = s_axis_tdata[60:58];
                    n_nt    = s_axis_tdata[61];
                    n_state = S_CMD;
                end
            end

            S_CMD: begin
                if (r_mode == MODE_TICK) begin
                    w_raddr = '0;
                    n_eidx  = '0;
                    n_nres  = '0;
                    n_state = S_SCAN;
                end else if (r_mode == MODE_NONE) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_okind = KIND_ACK;
                    n_odir  = 1'b0;
                    n_olast = 1'b1;
                    n_ostat = ST_OK;
                    n_oslot = r_tgt;
                    n_state = S_IDLE;
                    if (r_mode == MODE_CREATE) begin
                        n_oslot = 3'd0;
                        if (r_ms == '0) begin
                            n_ostat = ST_ZERO_IV;
                        end else if (!w_free_found) begin
                            n_ostat = ST_NO_FREE;
                        end else begin
                            n_oslot             = 3'(w_free_idx);
                            n_flags[w_free_idx] = {1'b1, r_nt, r_fl};
                            w_iv_we             = 1'b1;
                            w_iv_waddr          = w_free_idx;
                            w_iv_wdata          = w_create_iv;
                            w_st_we             = 1'b1;
                            w_st_waddr          = w_free_idx;
                        end
                    end else if (!w_tflags.used) begin
                        n_ostat = ST_NOT_USED;
                    end else begin
                        case (r_mode)
                            MODE_DESTROY: begin
                                n_flags[w_tidx] = '0;
                            end
                            MODE_START: begin
                                n_flags[w_tidx].enabled = 1'b1;
                                w_st_we                 = 1'b1;
                            end
                            MODE_STOP: begin
                                n_flags[w_tidx].enabled = 1'b0;
                            end
                            MODE_SETFL: begin
                                n_flags[w_tidx] = {1'b1, w_tflags.notify, r_fl};
                                w_st_we         = r_fl[0];
                            end
                            default: begin
                                // Set interval: stored as converted, without the minimum.
                                w_iv_we = 1'b1;
                                w_st_we = w_tflags.enabled;
                            end
                        endcase
                    end
                end
            end

            S_SCAN: begin
                if (w_stall) begin
                    w_raddr = r_eidx;
                end else begin
                    if (w_hit) begin
                        if (w_eflags.auto_rep) begin
                            w_st_we    = 1'b1;
                            w_st_waddr = r_eidx;
                        end else begin
                            n_flags[r_eidx].enabled = 1'b0;
                        end
                    end
                    if (w_fire) begin
                        if (r_pvld) begin
                            n_ovld  = 1'b1;
                            n_okind = KIND_FIRE;
                            n_ostat = ST_OK;
                            n_oslot = r_pslot;
                            n_odir  = r_pdir;
                            n_olast = 1'b0;
                        end
                        n_pvld  = 1'b1;
                        n_pslot = 3'(r_eidx);
                        n_pdir  = w_eflags.direct;
                        n_nres  = r_nres + CNT_W'(1);
                    end
                    if (r_eidx == IDX_W'(NUM_TIMERS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_eidx = r_eidx + IDX_W'(1);
                    end
                end
            end

            S_FLUSH: begin
                if (!r_pvld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_okind = KIND_FIRE;
                    n_ostat = ST_OK;
                    n_oslot = r_pslot;
                    n_odir  = r_pdir;
                    n_olast = 1'b1;
                    n_pvld  = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Interval and start memories: one write port and one registered read port each.
    // During a scan the write goes to the slot just evaluated while the read fetches the
    // next one, so the two never meet on one entry.
    always_ff @(posedge i_clk) begin
        if (w_iv_we) begin
            r_mem_iv[w_iv_waddr] <= w_iv_wdata;
        end
        if (w_st_we) begin
            r_mem_st[w_st_waddr] <= r_now;
        end
        r_iv_q <= r_mem_iv[w_raddr];
        r_st_q <= r_mem_st[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= MIN_IV_RESET;
            r_eidx  <= '0;
            r_nres  <= '0;
            r_pvld  <= 1'b0;
            r_ovld  <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_flags[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            r_eidx  <= n_eidx;
            r_nres  <= n_nres;
            r_pvld  <= n_pvld;
            r_ovld  <= n_ovld;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_tgt   <= n_tgt;
        r_now   <= n_now;
        r_ms    <= n_ms;
        r_fl    <= n_fl;
        r_nt    <= n_nt;
        r_pslot <= n_pslot;
        r_pdir  <= n_pdir;
        r_okind <= n_okind;
        r_ostat <= n_ostat;
        r_oslot <= n_oslot;
        r_odir  <= n_odir;
        r_olast <= n_olast;
    end

    // A held fire result never outlives its tick.
    `ASSERT_IMPLY(a_pend_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_pvld)
    // A tick never reports more fire results than the cap.
    `ASSERT_ALWAYS(a_res_cap, i_clk, i_rst_n, r_nres <= CNT_W'(MAX_RESULTS))
    // Every accepted item enters CMD in the next cycle.
    `ASSERT_IMPLY_NEXT(a_acc_cmd, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == S_CMD)
    // A stalled scan keeps its slot and its held result.
    `ASSERT_IMPLY_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, $stable(r_eidx) && r_pvld)

endmodule

// ===== tb/sv/periodic_oneshot_timer_bank_tb.sv =====
// Self-checking testbench for periodic_oneshot_timer_bank: directed and random command/tick
// streams, scored against an in-bench prediction of the timer slots. Depends on potb_pkg.
`timescale 1ns / 1ps

module periodic_oneshot_timer_bank_tb;
    import potb_pkg::*;

    // Flag bits as they travel in flag_bits.
    localparam logic [2:0] FL_ENABLE = 3'b001;
    localparam logic [2:0] FL_REPEAT = 3'b010;
    localparam logic [2:0] FL_DIRECT = 3'b100;

    // A tick walks every slot and may then wait on the output, so the block can stay busy
    // for a while after its last result; this many cycles cover that.
    localparam int SETTLE_CYCLES  = 2 * NUM_TIMERS + 8;
    // Longest correct quiet stretch is the deliberate receiver hold-off.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  tgt;
        logic [31:0] now;
        logic [22:0] ms;
        logic [2:0]  fl;
        logic        nt;
    } t_timer_cmd;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [2:0] slot;
        logic       direct;
        logic       last;
    } t_bank_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [MIN_IV_W-1:0]  i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // tdata, from bit 0: target_slot[3], now_us[32], interval_ms[23], flag_bits[3],
    // notify[1], two zero pad bits.
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // tuser: mode[3].
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // tdata, from bit 0: status[2], slot[3], direct[1], two zero pad bits.
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // tuser: kind[1].
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    periodic_oneshot_timer_bank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predicted state of the timer slots and the minimum-interval register.
    t_slot_flags         slot_state [NUM_TIMERS];
    logic [31:0]         slot_period_us [NUM_TIMERS];
    logic [31:0]         slot_start_us [NUM_TIMERS];
    logic [MIN_IV_W-1:0] min_interval_us;

    // Results still owed by the block, oldest first.
    t_bank_result pending_results [$];

    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          gaps_on = 1'b1;
    int          rx_hold_len = 0;
    // Free-running microsecond count that the random stimulus keeps.
    logic [31:0] clock_us = 32'd0;

    function automatic t_bank_result make_result(input logic kind, input logic [1:0] status,
                                                 input logic [2:0] slot, input logic direct,
                                                 input logic last);
        t_bank_result r;
        r.kind   = kind;
        r.status = status;
        r.slot   = slot;
        r.direct = direct;
        r.last   = last;
        return r;
    endfunction

    function automatic t_timer_cmd mk_cmd(input logic [2:0] mode, input logic [2:0] tgt,
                                          input logic [31:0] now, input logic [22:0] ms,
                                          input logic [2:0] fl, input logic nt);
        t_timer_cmd c;
        c.mode = mode;
        c.tgt  = tgt;
        c.now  = now;
        c.ms   = ms;
        c.fl   = fl;
        c.nt   = nt;
        return c;
    endfunction

    // Idle length before a transfer or between ready phases: mostly none, sometimes a few
    // cycles, rarely a long gap.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Advances the predicted timer bank by one accepted item and queues the results it owes.
    task automatic predict_timer_item(input t_timer_cmd c);
        t_bank_result fires [MAX_RESULTS];
        int           n;
        int           free_idx;
        logic [31:0]  period;
        logic [31:0]  elapsed;
        n = 0;
        free_idx = -1;
        case (c.mode)
            MODE_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (slot_state[i].used && slot_state[i].enabled) begin
                        elapsed = c.now - slot_start_us[i];
                        if (elapsed >= slot_period_us[i]) begin
                            // Only the first MAX_RESULTS notifying expiries report; every expiry reloads or stops.
                            if (slot_state[i].notify && n < MAX_RESULTS) begin
                                fires[n] = make_result(KIND_FIRE, ST_OK, 3'(i),
                                                       slot_state[i].direct, 1'b0);
                                n++;
                            end
                            if (slot_state[i].auto_rep)
                                slot_start_us[i] = c.now;
                            else
                                slot_state[i].enabled = 1'b0;
                        end
                    end
                end
                for (int k = 0; k < n; k++) begin
                    if (k == n - 1)
                        fires[k].last = 1'b1;
                    pending_results.push_back(fires[k]);
                end
            end
            MODE_CREATE: begin
                // The zero-interval check wins over the free-slot check.
                if (c.ms == '0) begin
                    pending_results.push_back(make_result(KIND_ACK, ST_ZERO_IV, 3'd0, 1'b0,
                                                          1'b1));
                end else begin
                    for (int i = NUM_TIMERS - 1; i >= 0; i--)
                        if (!slot_state[i].used)
                            free_idx = i;
                    if (free_idx < 0) begin
                        pending_results.push_back(make_result(KIND_ACK, ST_NO_FREE, 3'd0,
                                                              1'b0, 1'b1));
                    end else begin
                        // Milliseconds to microseconds wraps at 32 bits, then is clamped.
                        period = {9'd0, c.ms} * 32'(MS_TO_US);
                        if (period < 32'(min_interval_us))
                            period = 32'(min_interval_us);
                        slot_state[free_idx].used     = 1'b1;
                        slot_state[free_idx].notify   = c.nt;
                        slot_state[free_idx].direct   = c.fl[2];
                        slot_state[free_idx].auto_rep = c.fl[1];
                        slot_state[free_idx].enabled  = c.fl[0];
                        slot_period_us[free_idx] = period;
                        slot_start_us[free_idx]  = c.now;
                        pending_results.push_back(make_result(KIND_ACK, ST_OK, 3'(free_idx),
                                                              1'b0, 1'b1));
                    end
                end
            end
            MODE_NONE: begin
                // The unused mode is dropped without a result.
            end
            default: begin
                if (!slot_state[c.tgt].used) begin
                    pending_results.push_back(make_result(KIND_ACK, ST_NOT_USED, c.tgt, 1'b0,
                                                          1'b1));
                end else begin
                    case (c.mode)
                        MODE_DESTROY: slot_state[c.tgt] = '0;
                        MODE_START: begin
                            slot_state[c.tgt].enabled = 1'b1;
                            slot_start_us[c.tgt] = c.now;
                        end
                        MODE_STOP: slot_state[c.tgt].enabled = 1'b0;
                        MODE_SETFL: begin
                            slot_state[c.tgt].direct   = c.fl[2];
                            slot_state[c.tgt].auto_rep = c.fl[1];
                            slot_state[c.tgt].enabled  = c.fl[0];
                            if (c.fl[0])
                                slot_start_us[c.tgt] = c.now;
                        end
                        default: begin
                            // Set interval takes the raw product, zero included.
                            slot_period_us[c.tgt] = {9'd0, c.ms} * 32'(MS_TO_US);
                            if (slot_state[c.tgt].enabled)
                                slot_start_us[c.tgt] = c.now;
                        end
                    endcase
                    pending_results.push_back(make_result(KIND_ACK, ST_OK, c.tgt, 1'b0,
                                                          1'b1));
                end
            end
        endcase
    endtask

    // Offers one item after a random gap and waits for its transfer. tvalid stays high on
    // return so that a back-to-back item needs no second assignment in the same step.
    task automatic send_timer_cmd(input t_timer_cmd c);
        int gap;
        gap = pick_idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c.nt, c.fl, c.ms, c.now, c.tgt};
        s_axis_tuser  <= c.mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_timer_item(c);
    endtask

    // Stops offering, waits for every owed result, then lets a trailing tick finish.
    task automatic wait_bank_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_interval(input logic [MIN_IV_W-1:0] value);
        wait_bank_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        min_interval_us = value;
        i_cfg_we <= 1'b0;
    endtask

    // Picks a slot that is in use most of the time, so that commands get past the
    // not-in-use check, and any slot otherwise.
    function automatic logic [2:0] pick_target();
        int used_list [$];
        for (int i = 0; i < NUM_TIMERS; i++)
            if (slot_state[i].used)
                used_list.push_back(i);
        if (used_list.size() == 0 || $urandom_range(0, 99) < 15)
            return 3'($urandom_range(0, NUM_TIMERS - 1));
        return 3'(used_list[$urandom_range(0, used_list.size() - 1)]);
    endfunction

    // Builds a well-formed random item: ticks move the microsecond count forward, commands
    // mostly address live slots with short intervals. A small share is noise.
    task automatic build_random_cmd(output t_timer_cmd c);
        int r;
        int rm;
        r = $urandom_range(0, 99);
        if (r < 38)
            c.mode = MODE_TICK;
        else if (r < 56)
            c.mode = MODE_CREATE;
        else if (r < 64)
            c.mode = MODE_DESTROY;
        else if (r < 72)
            c.mode = MODE_START;
        else if (r < 79)
            c.mode = MODE_STOP;
        else if (r < 88)
            c.mode = MODE_SETFL;
        else if (r < 97)
            c.mode = MODE_SETIV;
        else
            c.mode = MODE_NONE;

        rm = $urandom_range(0, 99);
        if (rm < 3)
            clock_us = $urandom;
        else if (c.mode != MODE_TICK)
            clock_us = clock_us + $urandom_range(0, 300);
        else if (rm < 75)
            clock_us = clock_us + $urandom_range(0, 25000);
        else
            clock_us = clock_us + $urandom_range(0, 1200000);
        c.now = clock_us;

        rm = $urandom_range(0, 99);
        if (rm < 75)
            c.ms = 23'($urandom_range(1, 20));
        else if (rm < 85)
            c.ms = '0;
        else if (rm < 95)
            c.ms = 23'($urandom);
        else
            c.ms = 23'($urandom_range(4294967, 8388607));

        c.tgt = pick_target();
        c.fl  = 3'($urandom_range(0, 7)) | (($urandom_range(0, 9) < 6) ? FL_ENABLE : 3'b000);
        c.nt  = ($urandom_range(0, 9) < 7);
    endtask

    // Every command on an empty bank, the unused mode, and a tick with nothing to do.
    task automatic test_empty_bank();
        send_timer_cmd(mk_cmd(MODE_TICK, 3'd0, 32'd0, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_NONE, 3'd7, 32'hFFFF_FFFF, 23'h7F_FFFF, 3'd7, 1'b1));
        send_timer_cmd(mk_cmd(MODE_DESTROY, 3'd3, 32'd10, 23'd1, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_START, 3'd7, 32'd10, 23'd1, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_STOP, 3'd0, 32'd10, 23'd1, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_SETFL, 3'd1, 32'd10, 23'd1, 3'd7, 1'b0));
        send_timer_cmd(mk_cmd(MODE_SETIV, 3'd6, 32'd10, 23'd5, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'd10, 23'd0, 3'd7, 1'b1));
    endtask

    // Creation edge cases, expiry across the counter wrap, a zero interval, a full bank
    // and a tick in which every slot fires.
    task automatic test_slot_lifecycle();
        // Slot 0: 1 ms repeating direct timer that starts just below the wrap.
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd5, 32'hFFFF_FFFF, 23'd1,
                              FL_ENABLE | FL_REPEAT | FL_DIRECT, 1'b1));
        // Slot 1: largest field value, whose microsecond product wraps.
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'd0, 23'h7F_FFFF, FL_ENABLE, 1'b1));
        // Slot 2: product wraps to 704 us and is raised to the minimum.
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'hFFFF_FF00, 23'd4294968,
                              FL_ENABLE | FL_DIRECT, 1'b1));
        // Slot 3: created disabled.
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'd0, 23'd2, 3'd0, 1'b1));
        // Elapsed times wrap through zero here; slots 0 and 2 expire.
        send_timer_cmd(mk_cmd(MODE_TICK, 3'd0, 32'h0000_03FF, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_STOP, 3'd3, 32'h0000_0400, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_SETIV, 3'd0, 32'h0000_0400, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_TICK, 3'd0, 32'h0000_0401, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_SETFL, 3'd3, 32'h0000_0500, 23'd0,
                              FL_ENABLE | FL_REPEAT, 1'b0));
        send_timer_cmd(mk_cmd(MODE_START, 3'd2, 32'h0000_0500, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_DESTROY, 3'd1, 32'h0000_0500, 23'd0, 3'd0, 1'b0));
        // Create takes the lowest free slot, first the one just freed.
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd5, FL_ENABLE, 1'b1));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd3,
                              FL_ENABLE | FL_DIRECT, 1'b1));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd3,
                              FL_ENABLE | FL_REPEAT, 1'b1));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd3, FL_ENABLE, 1'b1));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd3,
                              FL_ENABLE | FL_REPEAT | FL_DIRECT, 1'b1));
        send_timer_cmd(mk_cmd(MODE_CREATE, 3'd0, 32'h0000_0600, 23'd3, FL_ENABLE, 1'b1));
        // Now every slot in use, enabled and notifying: the next tick fires all of them.
        send_timer_cmd(mk_cmd(MODE_TICK, 3'd0, 32'h0100_0000, 23'd0, 3'd0, 1'b0));
        send_timer_cmd(mk_cmd(MODE_TICK, 3'd0, 32'h0100_0000, 23'd0, 3'd0, 1'b0));
        clock_us = 32'h0100_0000;
    endtask

    // One phase of random traffic at a given minimum interval.
    task automatic test_random_traffic(input int count, input logic [MIN_IV_W-1:0] min_iv,
                                       input bit with_gaps);
        t_timer_cmd c;
        write_min_interval(min_iv);
        gaps_on = with_gaps;
        for (int i = 0; i < count; i++) begin
            build_random_cmd(c);
            send_timer_cmd(c);
            // Halfway through, the sender pauses until every result is back.
            if (i == count / 2)
                wait_bank_idle();
        end
        gaps_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering, so the
    // block backs up and stalls its input.
    task automatic test_output_backpressure();
        t_timer_cmd c;
        wait_bank_idle();
        gaps_on = 1'b0;
        rx_hold_len = RX_HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            build_random_cmd(c);
            send_timer_cmd(c);
        end
        wait_bank_idle();
        gaps_on = 1'b1;
    endtask

    // Receiver: random ready gaps, plus the long hold-off when one is requested.
    initial begin : rx_ready
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall = pick_idle_len();
            end
        end
    end

    // Scoreboard: each result transfer is compared with the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_bank_result got;
        t_bank_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = make_result(m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[4:2],
                              m_axis_tdata[5], m_axis_tlast);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("%0t: unexpected result kind %0d status %0d slot %0d",
                           $realtime, got.kind, got.status, got.slot);
                    $display(" direct %0d last %0d", got.direct, got.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%0t: mismatch: expected kind %0d status %0d slot %0d",
                               $realtime, want.kind, want.status, want.slot);
                        $write(" direct %0d last %0d, got kind %0d status %0d",
                               want.direct, want.last, got.kind, got.status);
                        $display(" slot %0d direct %0d last %0d",
                                 got.slot, got.direct, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : main
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TICK;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_state[i]     = '0;
            slot_period_us[i] = '0;
            slot_start_us[i]  = '0;
        end
        min_interval_us = MIN_IV_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_bank();
        test_slot_lifecycle();
        test_random_traffic(85, 20'd1, 1'b1);
        test_random_traffic(85, 20'hF_FFFF, 1'b1);
        test_output_backpressure();
        test_random_traffic(85, 20'd1000000, 1'b0);
        test_random_traffic(85, MIN_IV_RESET, 1'b1);

        wait_bank_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/potb_pkg.sv
design/periodic_oneshot_timer_bank.sv
tb/sv/periodic_oneshot_timer_bank_tb.sv
